### rtl/rci_pkg.sv
// shared types, opcodes and command codes of the robot command interpreter
`timescale 1ns / 1ps
`default_nettype none

package rci_pkg;

   localparam int unsigned OpW   = 8;
   localparam int unsigned ArgW  = 8;
   localparam int unsigned IdxW  = 15;
   localparam int unsigned CmdW  = 4;
   localparam int unsigned DutyW = 7;

   localparam logic [OpW-1:0] OP_START      = 8'h01;
   localparam logic [OpW-1:0] OP_WAIT       = 8'h02;
   localparam logic [OpW-1:0] OP_LED_GREEN  = 8'h44;
   localparam logic [OpW-1:0] OP_LED_OFF    = 8'h45;
   localparam logic [OpW-1:0] OP_SOUND_ON   = 8'h48;
   localparam logic [OpW-1:0] OP_SOUND_OFF  = 8'h09;
   localparam logic [OpW-1:0] OP_STOP       = 8'h60;
   localparam logic [OpW-1:0] OP_STOP_ALT   = 8'h61;
   localparam logic [OpW-1:0] OP_FORWARD    = 8'h62;
   localparam logic [OpW-1:0] OP_BACKWARD   = 8'h63;
   localparam logic [OpW-1:0] OP_TURN_RIGHT = 8'h64;
   localparam logic [OpW-1:0] OP_TURN_LEFT  = 8'h65;
   localparam logic [OpW-1:0] OP_LOOP_START = 8'hC0;
   localparam logic [OpW-1:0] OP_LOOP_END   = 8'hC1;
   localparam logic [OpW-1:0] OP_END        = 8'hFF;

   localparam logic [DutyW-1:0] TURN_DUTY = 7'd50;

   typedef enum logic [CmdW-1:0] {
      CMD_NONE       = 4'd0,
      CMD_WAIT       = 4'd1,
      CMD_LED_GREEN  = 4'd2,
      CMD_LED_OFF    = 4'd3,
      CMD_LED_RED    = 4'd4,
      CMD_SOUND_ON   = 4'd5,
      CMD_SOUND_OFF  = 4'd6,
      CMD_STOP       = 4'd7,
      CMD_FORWARD    = 4'd8,
      CMD_BACKWARD   = 4'd9,
      CMD_TURN_RIGHT = 4'd10,
      CMD_TURN_LEFT  = 4'd11
   } cmd_type;

   typedef struct packed {
      logic [OpW-1:0]  opcode;
      logic [ArgW-1:0] operand;
      logic [IdxW-1:0] pair_index;
   } req_type;

   typedef struct packed {
      cmd_type          command;
      logic [ArgW-1:0]  argument;
      logic [DutyW-1:0] left_duty;
      logic [DutyW-1:0] right_duty;
      logic             wheels_forward;
      logic             jump;
      logic [IdxW-1:0]  jump_target;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/rci_in_stage.sv
// input register holding one fetched opcode and operand word
`timescale 1ns / 1ps
`default_nettype none

module rci_in_stage import rci_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_word,
   input  wire logic    advance,
   output logic         word_valid,
   output req_type      word
);

   logic    valid_ff, valid_in;
   req_type word_ff, word_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_ready) begin
         valid_in = req_valid;
         word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

`default_nettype wire

### rtl/rci_exec.sv
// opcode decode with run flag and single level loop registers
`timescale 1ns / 1ps
`default_nettype none

module rci_exec import rci_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type word,
   input  wire logic    advance,
   output rsp_type      result
);

   logic            running_ff, running_in;
   logic [ArgW-1:0] loop_count_ff, loop_count_in;
   logic [IdxW-1:0] loop_return_ff, loop_return_in;
   logic [DutyW-1:0] speed;

   // operand * 100 / 255 via reciprocal: (x + 1 + (x >> 8)) >> 8
   function automatic logic [DutyW-1:0] speed_of(input logic [ArgW-1:0] v);
      logic [14:0] prod;
      logic [15:0] sum;
      prod = {7'd0, v} * 15'd100;
      sum  = {1'b0, prod} + 16'd1 + {9'd0, prod[14:8]};
      return sum[14:8];
   endfunction

   assign speed = speed_of(word.operand);

   always_comb begin
      running_in     = running_ff;
      loop_count_in  = loop_count_ff;
      loop_return_in = loop_return_ff;
      result         = '0;
      result.command = CMD_NONE;
      if (word.opcode == OP_START) begin
         running_in = 1'b1;
      end else if (running_ff) begin
         unique case (word.opcode) inside
            OP_WAIT: begin
               result.command  = CMD_WAIT;
               result.argument = word.operand;
            end
            OP_LED_GREEN:  result.command = CMD_LED_GREEN;
            OP_LED_OFF:    result.command = CMD_LED_OFF;
            OP_SOUND_ON: begin
               result.command  = CMD_SOUND_ON;
               result.argument = word.operand;
            end
            OP_SOUND_OFF:  result.command = CMD_SOUND_OFF;
            OP_STOP, OP_STOP_ALT: result.command = CMD_STOP;
            OP_FORWARD: begin
               result.command        = CMD_FORWARD;
               result.wheels_forward = 1'b1;
               result.left_duty      = speed;
               result.right_duty     = speed;
            end
            OP_BACKWARD: begin
               result.command    = CMD_BACKWARD;
               result.left_duty  = speed;
               result.right_duty = speed;
            end
            OP_TURN_RIGHT: begin
               result.command        = CMD_TURN_RIGHT;
               result.wheels_forward = 1'b1;
               result.right_duty     = TURN_DUTY;
            end
            OP_TURN_LEFT: begin
               result.command        = CMD_TURN_LEFT;
               result.wheels_forward = 1'b1;
               result.left_duty      = TURN_DUTY;
            end
            OP_LOOP_START: begin
               loop_count_in  = word.operand;
               loop_return_in = word.pair_index + IdxW'(1);
            end
            OP_LOOP_END: begin
               if (loop_count_ff != '0) begin
                  loop_count_in      = loop_count_ff - ArgW'(1);
                  result.jump        = 1'b1;
                  result.jump_target = loop_return_ff;
               end
            end
            OP_END: begin
               running_in     = 1'b0;
               result.command = CMD_LED_RED;
            end
            default: result.command = CMD_LED_RED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         loop_count_ff  <= '0;
         loop_return_ff <= '0;
      end else if (advance) begin
         running_ff     <= running_in;
         loop_count_ff  <= loop_count_in;
         loop_return_ff <= loop_return_in;
      end
   end

endmodule

`default_nettype wire

### rtl/robot_command_interpreter_top.sv
// top level of the robot command interpreter with result register
`timescale 1ns / 1ps
`default_nettype none

// Decodes one opcode/operand word per cycle into one command word while
// rsp_ready does not stall the result register. A request word is registered,
// decoded against the run flag and loop registers, and the command lands in the
// result register, which raises rsp_valid. An empty input register still takes
// a request while a finished command waits on rsp_ready.
module robot_command_interpreter_top import rci_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [OpW-1:0]   req_opcode,
   input  wire logic [ArgW-1:0]  req_operand,
   input  wire logic [IdxW-1:0]  req_pair_index,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [CmdW-1:0]       rsp_command,
   output logic [ArgW-1:0]       rsp_argument,
   output logic [DutyW-1:0]      rsp_left_duty,
   output logic [DutyW-1:0]      rsp_right_duty,
   output logic                  rsp_wheels_forward,
   output logic                  rsp_jump,
   output logic [IdxW-1:0]       rsp_jump_target
);

   req_type req_word, word;
   logic    word_valid, advance;
   rsp_type result;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   assign req_word = '{opcode: req_opcode, operand: req_operand,
                       pair_index: req_pair_index};

   assign advance = word_valid && (!out_valid_ff || rsp_ready);

   rci_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   rci_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .word    (word),
      .advance (advance),
      .result  (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (!out_valid_ff || rsp_ready) begin
         out_valid_in = word_valid;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_command        = out_ff.command;
   assign rsp_argument       = out_ff.argument;
   assign rsp_left_duty      = out_ff.left_duty;
   assign rsp_right_duty     = out_ff.right_duty;
   assign rsp_wheels_forward = out_ff.wheels_forward;
   assign rsp_jump           = out_ff.jump;
   assign rsp_jump_target    = out_ff.jump_target;

   // a jump word carries no other command
   a_jump_no_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_jump |-> rsp_command == CMD_NONE)
      else $error("jump word with a command");

   // target is zero unless jumping
   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_jump |-> rsp_jump_target == '0)
      else $error("jump target without jump");

   // duties stay within percent
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_duty <= 7'd100 && rsp_right_duty <= 7'd100)
      else $error("duty above 100");

   // an empty input register always takes a word
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !word_valid |-> req_ready)
      else $error("input stalled while empty");

   // a stalled result word holds
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_ff))
      else $error("result word changed while stalled");

endmodule

`default_nettype wire

### dv/robot_command_interpreter_top_tb.sv
// testbench of the robot command interpreter: program walks with loops, noise and random idling
`timescale 1ns / 1ps

import rci_pkg::*;

class command_scoreboard;
   bit               running = 1'b0;
   logic [ArgW-1:0]  loop_count = '0;
   logic [IdxW-1:0]  loop_return = '0;
   rsp_type          pending[$];
   rsp_type          last_word;
   int               decoded_words = 0;
   int               mismatches = 0;

   function logic [DutyW-1:0] duty_of(logic [ArgW-1:0] v);
      return DutyW'((int'(v) * 100) / 255);
   endfunction

   function void note_word(logic [OpW-1:0] op, logic [ArgW-1:0] operand,
                           logic [IdxW-1:0] idx);
      rsp_type w;
      w = '0;
      if (op == OP_START || running) decoded_words++;
      if (op == OP_START) begin
         running = 1'b1;
      end else if (running) begin
         case (op)
            OP_WAIT: begin
               w.command = CMD_WAIT;
               w.argument = operand;
            end
            OP_LED_GREEN: w.command = CMD_LED_GREEN;
            OP_LED_OFF: w.command = CMD_LED_OFF;
            OP_SOUND_ON: begin
               w.command = CMD_SOUND_ON;
               w.argument = operand;
            end
            OP_SOUND_OFF: w.command = CMD_SOUND_OFF;
            OP_STOP, OP_STOP_ALT: w.command = CMD_STOP;
            OP_FORWARD: begin
               w.command = CMD_FORWARD;
               w.wheels_forward = 1'b1;
               w.left_duty = duty_of(operand);
               w.right_duty = duty_of(operand);
            end
            OP_BACKWARD: begin
               w.command = CMD_BACKWARD;
               w.left_duty = duty_of(operand);
               w.right_duty = duty_of(operand);
            end
            OP_TURN_RIGHT: begin
               w.command = CMD_TURN_RIGHT;
               w.wheels_forward = 1'b1;
               w.right_duty = TURN_DUTY;
            end
            OP_TURN_LEFT: begin
               w.command = CMD_TURN_LEFT;
               w.wheels_forward = 1'b1;
               w.left_duty = TURN_DUTY;
            end
            OP_LOOP_START: begin
               loop_count = operand;
               loop_return = idx + 15'd1;
            end
            OP_LOOP_END: begin
               if (loop_count != '0) begin
                  loop_count = loop_count - 8'd1;
                  w.jump = 1'b1;
                  w.jump_target = loop_return;
               end
            end
            OP_END: begin
               running = 1'b0;
               w.command = CMD_LED_RED;
            end
            default: w.command = CMD_LED_RED;
         endcase
      end
      last_word = w;
      pending.push_back(w);
   endfunction

   function void check_field(string fname, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", fname, exp_v, got_v);
      end
   endfunction

   function void check_word(rsp_type got);
      rsp_type w;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result word: command %0d", int'(got.command));
         return;
      end
      w = pending.pop_front();
      check_field("command", int'(w.command), int'(got.command));
      check_field("argument", w.argument, got.argument);
      check_field("left_duty", w.left_duty, got.left_duty);
      check_field("right_duty", w.right_duty, got.right_duty);
      check_field("wheels_forward", w.wheels_forward, got.wheels_forward);
      check_field("jump", w.jump, got.jump);
      check_field("jump_target", w.jump_target, got.jump_target);
   endfunction
endclass

module robot_command_interpreter_top_tb;

   localparam int RandomWords = 1600;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [OpW-1:0]   req_opcode;
   logic [ArgW-1:0]  req_operand;
   logic [IdxW-1:0]  req_pair_index;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [CmdW-1:0]  rsp_command;
   logic [ArgW-1:0]  rsp_argument;
   logic [DutyW-1:0] rsp_left_duty;
   logic [DutyW-1:0] rsp_right_duty;
   logic             rsp_wheels_forward;
   logic             rsp_jump;
   logic [IdxW-1:0]  rsp_jump_target;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   command_scoreboard sb = new();

   robot_command_interpreter_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_operand        (req_operand),
      .req_pair_index     (req_pair_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command        (rsp_command),
      .rsp_argument       (rsp_argument),
      .rsp_left_duty      (rsp_left_duty),
      .rsp_right_duty     (rsp_right_duty),
      .rsp_wheels_forward (rsp_wheels_forward),
      .rsp_jump           (rsp_jump),
      .rsp_jump_target    (rsp_jump_target)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // result side: check accepted words, then pick next ready
   initial begin
      rsp_type got;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.command = cmd_type'(rsp_command);
            got.argument = rsp_argument;
            got.left_duty = rsp_left_duty;
            got.right_duty = rsp_right_duty;
            got.wheels_forward = rsp_wheels_forward;
            got.jump = rsp_jump;
            got.jump_target = rsp_jump_target;
            sb.check_word(got);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic send_word(logic [OpW-1:0] op, logic [ArgW-1:0] operand,
                            logic [IdxW-1:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_operand <= operand;
      req_pair_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(op, operand, idx);
   endtask

   function automatic logic [OpW-1:0] pick_body_op();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return OP_LOOP_START;
      if (pick < 22) return OP_LOOP_END;
      if (pick < 30) return OpW'($urandom_range(0, 255));
      case ($urandom_range(0, 10))
         0: return OP_WAIT;
         1: return OP_LED_GREEN;
         2: return OP_LED_OFF;
         3: return OP_SOUND_ON;
         4: return OP_SOUND_OFF;
         5: return OP_STOP;
         6: return OP_STOP_ALT;
         7: return OP_FORWARD;
         8: return OP_BACKWARD;
         9: return OP_TURN_RIGHT;
         default: return OP_TURN_LEFT;
      endcase
   endfunction

   // one short program, fetched the way the robot would, following jumps
   task automatic run_program();
      logic [OpW-1:0]  ops [16];
      logic [ArgW-1:0] args [16];
      logic [IdxW-1:0] base;
      logic [IdxW-1:0] rel;
      int len;
      int pc;
      int steps;
      len = $urandom_range(3, 14);
      for (int i = 0; i < len; i++) begin
         ops[i] = pick_body_op();
         args[i] = ArgW'($urandom_range(0, 255));
         if (ops[i] == OP_LOOP_START && $urandom_range(0, 9) < 8)
            args[i] = ArgW'($urandom_range(0, 3));
      end
      if ($urandom_range(0, 9) != 0) ops[0] = OP_START;
      if ($urandom_range(0, 9) != 0) ops[len-1] = OP_END;
      if ($urandom_range(0, 9) == 0)
         base = 15'h7FFF - IdxW'($urandom_range(0, len - 1));
      else
         base = IdxW'($urandom_range(0, 32767));
      pc = 0;
      steps = 0;
      while (pc < len && steps < 80) begin
         send_word(ops[pc], args[pc], base + IdxW'(pc));
         steps++;
         if (sb.last_word.jump) begin
            rel = sb.last_word.jump_target - base;
            pc = int'(rel);
         end else begin
            pc++;
         end
      end
   endtask

   initial begin
      int phase;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= '0;
      req_operand <= '0;
      req_pair_index <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ignored before start
      send_word(OP_WAIT, 8'hFF, 15'd0);
      send_word(OP_LOOP_END, 8'h00, 15'd1);
      send_word(OP_START, 8'h00, 15'd2);
      // loop end with no loop start
      send_word(OP_LOOP_END, 8'hFF, 15'd3);
      send_word(OP_WAIT, 8'hFF, 15'd4);
      send_word(OP_WAIT, 8'h00, 15'd5);
      send_word(OP_LED_GREEN, 8'hAA, 15'd6);
      send_word(OP_LED_OFF, 8'h55, 15'd7);
      send_word(OP_SOUND_ON, 8'hFF, 15'd8);
      send_word(OP_SOUND_OFF, 8'h01, 15'd9);
      send_word(OP_STOP, 8'h00, 15'd10);
      send_word(OP_STOP_ALT, 8'hFF, 15'd11);
      send_word(OP_FORWARD, 8'hFF, 15'd12);
      send_word(OP_FORWARD, 8'h00, 15'd13);
      send_word(OP_BACKWARD, 8'h80, 15'd14);
      send_word(OP_TURN_RIGHT, 8'hFF, 15'd15);
      send_word(OP_TURN_LEFT, 8'h00, 15'd16);
      send_word(8'h00, 8'h00, 15'd17);
      send_word(OP_START, 8'hFF, 15'd18);
      // loop start on the last index, return wraps to zero
      send_word(OP_LOOP_START, 8'd2, 15'h7FFF);
      send_word(OP_LOOP_END, 8'h00, 15'd0);
      send_word(OP_LOOP_END, 8'h00, 15'd0);
      send_word(OP_LOOP_END, 8'h00, 15'd0);
      send_word(OP_END, 8'h00, 15'h7FFE);
      send_word(OP_FORWARD, 8'hFF, 15'd20);

      while (sb.decoded_words < RandomWords + 25) begin
         phase = (sb.decoded_words * 4) / (RandomWords + 25);
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
            default: begin send_idle_pct = 25; rsp_stall_pct = 25; end
         endcase
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 5))
               send_word(OpW'($urandom_range(0, 255)), ArgW'($urandom_range(0, 255)),
                         IdxW'($urandom_range(0, 32767)));
         end else begin
            run_program();
         end
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
rtl/rci_pkg.sv
rtl/rci_in_stage.sv
rtl/rci_exec.sv
rtl/robot_command_interpreter_top.sv
dv/robot_command_interpreter_top_tb.sv
